// ----- hw/rtl/ppikms_pkg.sv -----
`timescale 1ns / 1ps

package ppikms_pkg;

	// Number of 12-bit rows in the key matrix (1 to 7)
	localparam int KEY_ROWS  = 7;
	localparam int ROW_IDX_W = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
	localparam int ROW_W     = 12;

	// Item commands; the fourth code is unused and does nothing
	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// Port selects
	typedef enum logic [1:0] {
		PORT_A    = 2'd0,
		PORT_B    = 2'd1,
		PORT_C    = 2'd2,
		PORT_CTRL = 2'd3
	} port_t;

	// Port C row select that shows the joypads
	localparam logic [2:0] SEL_PADS = 3'd7;

	// Key event toward the matrix
	typedef struct packed {
		logic       en;
		logic [7:0] code;
	} key_evt_t;

	// Bus access toward the port block
	typedef struct packed {
		logic       rd;
		logic       wr;
		port_t      port;
		logic [7:0] data;
	} bus_op_t;

	// Scan code to matrix position: high nibble is row plus one, low nibble is column
	function automatic logic [7:0] key_pos(input logic [6:0] idx);
		logic [7:0] pos;
		case (idx)
			7'd1:  pos = 8'h10;
			7'd2:  pos = 8'h20;
			7'd3:  pos = 8'h30;
			7'd4:  pos = 8'h40;
			7'd5:  pos = 8'h50;
			7'd6:  pos = 8'h60;
			7'd7:  pos = 8'h70;
			7'd8:  pos = 8'h18;
			7'd9:  pos = 8'h28;
			7'd10: pos = 8'h38;
			7'd15: pos = 8'h11;
			7'd16: pos = 8'h21;
			7'd17: pos = 8'h31;
			7'd18: pos = 8'h41;
			7'd19: pos = 8'h51;
			7'd20: pos = 8'h61;
			7'd21: pos = 8'h71;
			7'd22: pos = 8'h17;
			7'd23: pos = 8'h27;
			7'd24: pos = 8'h37;
			7'd26: pos = 8'h66;
			7'd29: pos = 8'h12;
			7'd30: pos = 8'h22;
			7'd31: pos = 8'h32;
			7'd32: pos = 8'h42;
			7'd33: pos = 8'h52;
			7'd34: pos = 8'h62;
			7'd35: pos = 8'h72;
			7'd36: pos = 8'h16;
			7'd37: pos = 8'h26;
			7'd38: pos = 8'h36;
			7'd43: pos = 8'h13;
			7'd44: pos = 8'h23;
			7'd45: pos = 8'h33;
			7'd46: pos = 8'h43;
			7'd47: pos = 8'h53;
			7'd48: pos = 8'h63;
			7'd49: pos = 8'h73;
			7'd50: pos = 8'h15;
			7'd51: pos = 8'h25;
			7'd52: pos = 8'h35;
			default: pos = 8'h00;
		endcase
		return pos;
	endfunction

endpackage

// ----- hw/rtl/ppikms_key_matrix.sv -----
`timescale 1ns / 1ps

module ppikms_key_matrix import ppikms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  key_evt_t             evt,
	input  logic [2:0]           row_sel,
	output logic [ROW_W-1:0]     row_bits
);

	logic [ROW_W-1:0] rows_q [KEY_ROWS];
	logic [7:0]       pos;
	logic [3:0]       row_num;
	logic [3:0]       col;
	logic             hit;
	logic [ROW_W-1:0] mask;

	// Decode the scan code into a row and column
	always_comb begin
		pos     = key_pos(evt.code[6:0]);
		row_num = pos[7:4] - 4'd1;
		col     = pos[3:0];
		hit     = evt.en && (pos != 8'h00) && (row_num < 4'(KEY_ROWS))
			&& (col < 4'(ROW_W));
		mask    = ROW_W'(1) << col;
	end

	// Press or release one bit of the addressed row
	for (genvar r = 0; r < KEY_ROWS; r++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rows_q[r] <= '0;
			end else if (hit && (row_num == 4'(r))) begin
				if (evt.code[7]) begin
					rows_q[r] <= rows_q[r] & ~mask;
				end else begin
					rows_q[r] <= rows_q[r] | mask;
				end
			end
		end
	end

	// Show the selected row; rows beyond the matrix read as no keys pressed
	always_comb begin
		if (row_sel < 3'(KEY_ROWS)) begin
			row_bits = rows_q[row_sel[ROW_IDX_W-1:0]];
		end else begin
			row_bits = '0;
		end
	end

endmodule

// ----- hw/rtl/ppikms_port_ctrl.sv -----
`timescale 1ns / 1ps

module ppikms_port_ctrl import ppikms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bus_op_t          op,
	input  logic [5:0]       pad_one,
	input  logic [5:0]       pad_two,
	input  logic [ROW_W-1:0] row_bits,
	output logic [2:0]       row_sel,
	output logic [7:0]       rd_data
);

	logic [7:0]       port_c_q;
	logic [ROW_W-1:0] row_inv;
	logic [7:0]       val;

	// Load port C whole, or set/reset one bit through the control port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_c_q <= '0;
		end else if (op.wr) begin
			if (op.port == PORT_C) begin
				port_c_q <= op.data;
			end else if (op.port == PORT_CTRL && !op.data[7]) begin
				port_c_q[op.data[3:1]] <= op.data[0];
			end
		end
	end

	assign row_sel = port_c_q[2:0];
	assign row_inv = ~row_bits;

	// Read mux: pressed keys and pad buttons read as zero
	always_comb begin
		case (op.port)
			PORT_A: begin
				if (row_sel == SEL_PADS) begin
					val = ~{pad_two[1:0], pad_one};
				end else begin
					val = row_inv[7:0];
				end
			end
			PORT_B: begin
				if (row_sel == SEL_PADS) begin
					val = {4'hF, ~pad_two[5:2]};
				end else begin
					val = {4'h0, row_inv[11:8]};
				end
			end
			PORT_C:  val = port_c_q;
			default: val = 8'hFF;
		endcase
		rd_data = op.rd ? val : 8'h00;
	end

endmodule

// ----- hw/rtl/ppi_keyboard_matrix_scanner.sv -----
`timescale 1ns / 1ps

// Keyboard matrix behind an 8255-style parallel port. Every transaction (key
// event, port read or port write) returns one read_data byte, zero for all but
// port reads. One transaction is taken per cycle while in_stall is low; its
// result passes through the input register, where the matrix and port C are
// updated and the read byte is formed, and then waits in the result register
// until the output side takes it.
// Reset clears the key matrix (no keys pressed) and port C.
module ppi_keyboard_matrix_scanner import ppikms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] key_code,
	input  logic [1:0] port,
	input  logic [7:0] write_data,
	input  logic [5:0] pad_one,
	input  logic [5:0] pad_two,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);

	logic             valid_s1;
	logic [1:0]       command_s1;
	logic [7:0]       key_code_s1;
	logic [1:0]       port_s1;
	logic [7:0]       write_data_s1;
	logic [5:0]       pad_one_s1;
	logic [5:0]       pad_two_s1;
	logic             out_valid_q;
	logic [7:0]       read_data_q;
	logic             advance;
	logic             fire;
	key_evt_t         evt;
	bus_op_t          op;
	logic [2:0]       row_sel;
	logic [ROW_W-1:0] row_bits;
	logic [7:0]       rd_data;

	// Move the stage on when the result register is free or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1    <= command;
			key_code_s1   <= key_code;
			port_s1       <= port;
			write_data_s1 <= write_data;
			pad_one_s1    <= pad_one;
			pad_two_s1    <= pad_two;
		end
	end

	// Decode the held transaction
	always_comb begin
		evt.en   = fire && (command_s1 == CMD_KEY);
		evt.code = key_code_s1;
		op.rd    = command_s1 == CMD_READ;
		op.wr    = fire && (command_s1 == CMD_WRITE);
		op.port  = port_t'(port_s1);
		op.data  = write_data_s1;
	end

	ppikms_key_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.row_sel  (row_sel),
		.row_bits (row_bits)
	);

	ppikms_port_ctrl u_port (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.pad_one  (pad_one_s1),
		.pad_two  (pad_two_s1),
		.row_bits (row_bits),
		.row_sel  (row_sel),
		.rd_data  (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= rd_data;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule
